// ----- src/ipv6p_pkg.sv -----
// ----------------------------------------------------------------------------
// ipv6p_pkg
// shared request types, character codes and hex digit decode for the
// ipv6 text address parser
// ----------------------------------------------------------------------------
package ipv6p_pkg;

    // one character request
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_t;

    // one parse result
    typedef struct packed {
        logic        valid_res;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } result_t;

    // decoded hex digit
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    localparam int unsigned GroupMax = 8;
    localparam int unsigned DigitMax = 4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = c[3:0];
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            h.val = c[3:0];
        end
        else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF))
        begin
            h.val = 4'(c[3:0] + 4'd9);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- src/ipv6p_scan.sv -----
// ----------------------------------------------------------------------------
// ipv6p_scan
// per-character parse state and the result formed on the final character
// ----------------------------------------------------------------------------
module ipv6p_scan
    import ipv6p_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  char_t   char_in,
    output result_t result
);

    localparam logic [2:0] PH_START      = 3'd0;
    localparam logic [2:0] PH_LEAD_COLON = 3'd1;
    localparam logic [2:0] PH_GROUP      = 3'd2;
    localparam logic [2:0] PH_COLON      = 3'd3;
    localparam logic [2:0] PH_GAP        = 3'd4;

    // groups before the gap sit at fixed slots, group 0 in slot 7;
    // groups after the gap shift in from the bottom so they end right-aligned
    logic [7:0][15:0] head_reg,   head_next;
    logic [7:0][15:0] tail_reg,   tail_next;
    logic [3:0]       count_reg,  count_next;
    logic [15:0]      accum_reg,  accum_next;
    logic [2:0]       digits_reg, digits_next;
    logic             gap_reg,    gap_next;
    logic [2:0]       phase_reg,  phase_next;
    logic             failed_reg, failed_next;

    hex_t             hex_c;
    logic             commit_c;
    logic [127:0]     addr_c;

    always_comb
    begin
        logic halt;
        halt        = 1'b0;
        hex_c       = hex_decode(char_in.ch);
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        accum_next  = accum_reg;
        digits_next = digits_reg;
        gap_next    = gap_reg;
        phase_next  = phase_reg;
        failed_next = failed_reg;
        commit_c    = 1'b0;

        if (!failed_reg)
        begin
            if (hex_c.ok)
            begin
                if (phase_reg == PH_LEAD_COLON)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    if (phase_reg != PH_GROUP)
                    begin
                        if (count_reg >= 4'(GroupMax))
                        begin
                            failed_next = 1'b1;
                            halt        = 1'b1;
                        end
                        else
                        begin
                            accum_next  = '0;
                            digits_next = '0;
                            phase_next  = PH_GROUP;
                        end
                    end
                    if (!halt)
                    begin
                        if (digits_next >= 3'(DigitMax))
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            accum_next  = {accum_next[11:0], hex_c.val};
                            digits_next = digits_next + 3'd1;
                        end
                    end
                end
            end
            else if (char_in.ch == CH_COLON)
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        phase_next = PH_LEAD_COLON;
                    end
                    PH_LEAD_COLON:
                    begin
                        gap_next   = 1'b1;
                        phase_next = PH_GAP;
                    end
                    PH_GROUP:
                    begin
                        commit_c   = 1'b1;
                        phase_next = PH_COLON;
                    end
                    PH_COLON:
                    begin
                        if (gap_reg)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            gap_next   = 1'b1;
                            phase_next = PH_GAP;
                        end
                    end
                    default:
                    begin
                        failed_next = 1'b1;
                    end
                endcase
            end
            else
            begin
                failed_next = 1'b1;
            end
        end

        // closing checks on the final character
        if (char_in.last && !failed_next)
        begin
            if (phase_next == PH_GROUP)
            begin
                commit_c = 1'b1;
            end
            else if (phase_next != PH_GAP)
            begin
                failed_next = 1'b1;
            end
        end

        // finish the group being read
        if (commit_c)
        begin
            if (count_next < 4'(GroupMax))
            begin
                if (gap_next)
                begin
                    tail_next = {tail_next[6:0], accum_next};
                end
                else
                begin
                    head_next[~count_next[2:0]] = accum_next;
                end
                count_next = count_next + 4'd1;
            end
            else
            begin
                failed_next = 1'b1;
            end
            accum_next  = '0;
            digits_next = '0;
        end

        if (char_in.last && !failed_next && !gap_next && count_next != 4'(GroupMax))
        begin
            failed_next = 1'b1;
        end

        addr_c           = failed_next ? '0 : (head_next | tail_next);
        result.valid_res = !failed_next;
        result.addr_high = addr_c[127:64];
        result.addr_low  = addr_c[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            accum_reg  <= '0;
            digits_reg <= '0;
            gap_reg    <= 1'b0;
            phase_reg  <= PH_START;
            failed_reg <= 1'b0;
        end
        else if (take)
        begin
            if (char_in.last)
            begin
                head_reg   <= '0;
                tail_reg   <= '0;
                count_reg  <= '0;
                accum_reg  <= '0;
                digits_reg <= '0;
                gap_reg    <= 1'b0;
                phase_reg  <= PH_START;
                failed_reg <= 1'b0;
            end
            else
            begin
                head_reg   <= head_next;
                tail_reg   <= tail_next;
                count_reg  <= count_next;
                accum_reg  <= accum_next;
                digits_reg <= digits_next;
                gap_reg    <= gap_next;
                phase_reg  <= phase_next;
                failed_reg <= failed_next;
            end
        end
    end

endmodule

// ----- src/ipv6_text_address_parser_top.sv -----
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_top
// parses the text form of an ipv6 address, one character per request
// ----------------------------------------------------------------------------
// usage
// - char channel: one ascii character per request, last set on the final one
// - res channel: one request per text, valid_res plus the 128-bit address as
//   addr_high (groups 0 to 3) and addr_low (groups 4 to 7), zero when invalid
// - one character is taken every cycle while char_stall is low; the parse state
//   updates in the cycle the character is accepted
// - the result appears in the output register in the cycle after the final
//   character is accepted
// - after each final character the parse state returns to its start values,
//   so the next text may begin in the very next cycle
// - reset clears the parse state and empties the output register
// - while a result waits with res_stall high, char_stall is raised and no
//   further character is taken; once the result leaves, a new result may be
//   loaded in the same cycle
// ----------------------------------------------------------------------------
module ipv6_text_address_parser_top
    import ipv6p_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    // character requests
    input  logic    char_valid,
    output logic    char_stall,
    input  char_t   char_data,
    // result requests
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res_data
);

    result_t res_reg;
    logic    res_valid_reg;
    logic    take;
    result_t result_c;

    // hold the input only while a finished result cannot leave
    assign char_stall = res_valid_reg && res_stall;
    assign take       = char_valid && !char_stall;

    ipv6p_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .char_in (char_data),
        .result  (result_c)
    );

    // output register, loaded on each accepted final character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take && char_data.last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && char_data.last)
        begin
            res_reg <= result_c;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule
